// ===== rtl/core/smpg_pkg.sv =====
// shared types, constants and helpers of the stepper move pulse generator
package smpg_pkg;

  // field widths
  localparam int unsigned SPD_W     = 10;   // speed in degrees per second
  localparam int unsigned ANG_W     = 16;   // angle, Q12.4 degrees
  localparam int unsigned SPDEG_W   = 24;   // microsteps per degree, Q8.16
  localparam int unsigned TICKS_W   = 32;   // ticks per step at 1 deg/s
  localparam int unsigned RES_W     = 18;   // carried residual, Q1.16 steps
  localparam int unsigned STEPS_W   = 17;   // step counter
  localparam int unsigned PROD_W    = ANG_W + SPDEG_W;   // angle times rate
  localparam int unsigned TGT_W     = PROD_W + 2;        // signed target
  localparam int unsigned N_W       = TGT_W - 20;        // signed rounded count
  localparam int unsigned DIVD_W    = TICKS_W + 1;       // period dividend

  // apb register map
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam logic [1:0] REG_SPDEG_A = 2'd0;
  localparam logic [1:0] REG_SPDEG_B = 2'd1;
  localparam logic [1:0] REG_TICKS_A = 2'd2;
  localparam logic [1:0] REG_TICKS_B = 2'd3;

  // register reset values
  localparam logic [SPDEG_W-1:0] SPDEG_A_RST = 24'd1048576;
  localparam logic [SPDEG_W-1:0] SPDEG_B_RST = 24'd582542;
  localparam logic [TICKS_W-1:0] TICKS_A_RST = 32'd62500;
  localparam logic [TICKS_W-1:0] TICKS_B_RST = 32'd112500;

  // default depth of the command queue
  localparam int unsigned QUEUE_DEPTH = 2;

  // input beat
  typedef struct packed {
    logic             req_type;
    logic             motor_select;
    logic             direction;
    logic [SPD_W-1:0] speed_dps;
    logic [ANG_W-1:0] move_degrees;
  } req_t;

  // result beat
  typedef struct packed {
    logic motor_a_step;
    logic motor_a_dir;
    logic motor_a_enable_n;
    logic motor_b_step;
    logic motor_b_dir;
    logic motor_b_enable_n;
    logic busy_res;
    logic rejected;
  } res_t;

  // request class decided at the front
  typedef enum logic [1:0] {
    OP_TICK,
    OP_MOVE,
    OP_ZERO_SPEED
  } op_e;

  // queue entry
  typedef struct packed {
    op_e              kind;
    logic             motor_select;
    logic             direction;
    logic [SPD_W-1:0] speed_dps;
    logic [ANG_W-1:0] move_degrees;
  } cmd_t;

  // configuration register bank
  typedef struct packed {
    logic [SPDEG_W-1:0] spdeg_a;
    logic [SPDEG_W-1:0] spdeg_b;
    logic [TICKS_W-1:0] ticks_a;
    logic [TICKS_W-1:0] ticks_b;
  } cfg_t;

  // line levels from the motion state
  function automatic res_t emit_lines(input logic               moving,
                                      input logic               active,
                                      input logic [TICKS_W-1:0] elapsed,
                                      input logic [TICKS_W-1:0] period,
                                      input logic [1:0]         dir_lines,
                                      input logic               rejected);
    res_t r;
    logic level;
    level              = moving && (elapsed < (period >> 1));
    r.motor_a_step     = moving && !active && level;
    r.motor_a_dir      = dir_lines[0];
    r.motor_a_enable_n = !(moving && !active);
    r.motor_b_step     = moving && active && level;
    r.motor_b_dir      = dir_lines[1];
    r.motor_b_enable_n = !(moving && active);
    r.busy_res         = moving;
    r.rejected         = rejected;
    return r;
  endfunction

endpackage

// ===== rtl/core/smpg_front.sv =====
// front end: accepts request beats, classifies them and queues them
module smpg_front #(
  parameter int unsigned QUEUE_DEPTH = smpg_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  smpg_pkg::req_t  in_data_i,
  output logic            head_valid_o,
  output smpg_pkg::cmd_t  head_o,
  input  logic            pop_i
);
  import smpg_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;
  cmd_t            cmd;

  // classify the incoming beat
  always_comb begin
    cmd.motor_select = in_data_i.motor_select;
    cmd.direction    = in_data_i.direction;
    cmd.speed_dps    = in_data_i.speed_dps;
    cmd.move_degrees = in_data_i.move_degrees;
    if (in_data_i.req_type) begin
      cmd.kind = OP_TICK;
    end else if (in_data_i.speed_dps == '0) begin
      cmd.kind = OP_ZERO_SPEED;
    end else begin
      cmd.kind = OP_MOVE;
    end
  end

  assign in_stall_o   = (cnt_q == FullCnt);
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = pop_i && head_valid_o;
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/smpg_div.sv =====
// restoring divider for the step period, one quotient bit per cycle
module smpg_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [smpg_pkg::DIVD_W-1:0]         dividend_i,
  input  logic [smpg_pkg::SPD_W-1:0]          divisor_i,
  output logic                                busy_o,
  output logic [smpg_pkg::DIVD_W-1:0]         quot_o
);
  import smpg_pkg::*;

  localparam int unsigned CntW = $clog2(DIVD_W + 1);

  logic [CntW-1:0]   cnt_q;
  logic [SPD_W-1:0]  rem_q, dsr_q;
  logic [DIVD_W-1:0] quo_q;
  logic [SPD_W:0]    rem_sh, rem_sub;
  logic              ge;

  // one restoring step
  assign rem_sh  = {rem_q, quo_q[DIVD_W-1]};
  assign ge      = (rem_sh >= {1'b0, dsr_q});
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  assign busy_o = (cnt_q != '0);
  assign quot_o = quo_q;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(DIVD_W);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_o) begin
      rem_q <= ge ? rem_sub[SPD_W-1:0] : rem_sh[SPD_W-1:0];
      quo_q <= {quo_q[DIVD_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/smpg_back.sv =====
// back end: executes ticks and moves, holds motion state and result register
module smpg_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  smpg_pkg::cfg_t  cfg_i,
  input  logic            head_valid_i,
  input  smpg_pkg::cmd_t  head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output smpg_pkg::res_t  out_data_o
);
  import smpg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_TGT,
    ST_RND,
    ST_ERR,
    ST_WAIT
  } state_e;

  localparam logic [TGT_W-1:0]   RoundHalf = TGT_W'(1) << 19;
  localparam logic [STEPS_W-1:0] StepsMax  = '1;

  state_e             state_q;
  logic [RES_W-1:0]   res_a_q, res_b_q;
  logic               last_dir_a_q, last_dir_b_q;
  logic [STEPS_W-1:0] steps_left_q;
  logic [TICKS_W-1:0] period_q, elapsed_q;
  logic               active_q, moving_q;
  logic [1:0]         dir_lines_q;
  logic               out_valid_q;
  res_t               out_data_q;

  // move datapath registers
  logic               mot_q, dir_q;
  logic [ANG_W-1:0]   ang_q;
  logic [SPDEG_W-1:0] spdeg_q;
  logic [RES_W:0]     r_q;
  logic [PROD_W-1:0]  prod_q;
  logic [TGT_W-1:0]   target_q;
  logic [N_W-1:0]     n_q;
  logic [RES_W-1:0]   res_new_q;

  logic               can_emit, do_tick, do_reject, do_start, finish;
  logic               div_busy;
  logic [DIVD_W-1:0]  div_quot, dividend;
  logic [RES_W-1:0]   res_sel;
  logic               last_sel;
  logic [RES_W:0]     r_ext, r_d;
  logic [TGT_W-1:0]   target_d, tgt_pos, tgt_mag, tgt_mag_rnd, err_d;
  logic [N_W-1:0]     n_d, n_mag;
  logic [TICKS_W-1:0] elapsed_inc, period_new;
  logic               tick_wrap, n_pos;
  logic [STEPS_W-1:0] steps_dec, steps_new;
  logic [1:0]         dir_new;

  // dispatch of the queue head
  assign can_emit = !out_valid_q || !out_stall_i;
  always_comb begin
    do_tick   = 1'b0;
    do_reject = 1'b0;
    do_start  = 1'b0;
    if (state_q == ST_IDLE && head_valid_i && can_emit) begin
      unique case (head_i.kind)
        OP_TICK:       do_tick   = 1'b1;
        OP_ZERO_SPEED: do_reject = 1'b1;
        OP_MOVE: begin
          do_reject = moving_q;
          do_start  = !moving_q;
        end
        default:       do_reject = 1'b1;
      endcase
    end
  end
  assign finish = (state_q == ST_WAIT) && !div_busy && can_emit;
  assign pop_o  = do_tick || do_reject || finish;

  // residual of the selected motor, negated on a direction change
  assign res_sel  = head_i.motor_select ? res_b_q : res_a_q;
  assign last_sel = head_i.motor_select ? last_dir_b_q : last_dir_a_q;
  assign r_ext    = {res_sel[RES_W-1], res_sel};
  assign r_d      = (head_i.direction != last_sel) ? (~r_ext + 1'b1) : r_ext;

  // period divider, rounded half up
  assign dividend = {1'b0, (head_i.motor_select ? cfg_i.ticks_b : cfg_i.ticks_a)}
                  + DIVD_W'(head_i.speed_dps[SPD_W-1:1]);

  smpg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (do_start),
    .dividend_i (dividend),
    .divisor_i  (head_i.speed_dps),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // target at 2^-20 step
  assign target_d = {2'b00, prod_q} - {{(TGT_W-RES_W-5){r_q[RES_W]}}, r_q, 4'h0};

  // round half away from zero
  assign tgt_pos     = target_q + RoundHalf;
  assign tgt_mag     = ~target_q + 1'b1;
  assign tgt_mag_rnd = tgt_mag + RoundHalf;
  assign n_mag       = tgt_mag_rnd[TGT_W-1:20];
  assign n_d         = target_q[TGT_W-1] ? (~n_mag + 1'b1) : tgt_pos[TGT_W-1:20];

  // rounding error, floored to 2^-16 step
  assign err_d = {n_q, 20'h0} - target_q;

  // move datapath
  always_ff @(posedge clk_i) begin
    if (do_start) begin
      mot_q   <= head_i.motor_select;
      dir_q   <= head_i.direction;
      ang_q   <= head_i.move_degrees;
      spdeg_q <= head_i.motor_select ? cfg_i.spdeg_b : cfg_i.spdeg_a;
      r_q     <= r_d;
    end
    case (state_q)
      ST_MUL:  prod_q    <= {{SPDEG_W{1'b0}}, ang_q} * {{ANG_W{1'b0}}, spdeg_q};
      ST_TGT:  target_q  <= target_d;
      ST_RND:  n_q       <= n_d;
      ST_ERR:  res_new_q <= err_d[RES_W+3:4];
      default: ;
    endcase
  end

  // tick advance
  assign elapsed_inc = elapsed_q + 1'b1;
  assign tick_wrap   = (elapsed_inc >= period_q);
  assign steps_dec   = steps_left_q - 1'b1;

  // move commit values
  assign n_pos      = !n_q[N_W-1] && (n_q != '0);
  assign steps_new  = (n_q[N_W-2:STEPS_W] != '0) ? StepsMax : n_q[STEPS_W-1:0];
  assign period_new = (div_quot[DIVD_W-1:1] == '0) ? TICKS_W'(2) : div_quot[TICKS_W-1:0];
  assign dir_new    = mot_q ? {dir_q, dir_lines_q[0]} : {dir_lines_q[1], dir_q};

  // sequencer, motion state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      res_a_q      <= '0;
      res_b_q      <= '0;
      last_dir_a_q <= 1'b0;
      last_dir_b_q <= 1'b0;
      steps_left_q <= '0;
      period_q     <= '0;
      elapsed_q    <= '0;
      active_q     <= 1'b0;
      dir_lines_q  <= '0;
      moving_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      // result valid: set by every retired beat, cleared once taken
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (do_start) begin
            state_q <= ST_MUL;
          end
          if (do_reject) begin
            out_data_q  <= emit_lines(moving_q, active_q, elapsed_q, period_q,
                                      dir_lines_q, 1'b1);
          end
          if (do_tick) begin
            out_data_q  <= emit_lines(moving_q, active_q, elapsed_q, period_q,
                                      dir_lines_q, 1'b0);
            if (moving_q) begin
              if (tick_wrap) begin
                elapsed_q    <= '0;
                steps_left_q <= steps_dec;
                if (steps_dec == '0) begin
                  moving_q <= 1'b0;
                end
              end else begin
                elapsed_q <= elapsed_inc;
              end
            end
          end
        end
        ST_MUL: state_q <= ST_TGT;
        ST_TGT: state_q <= ST_RND;
        ST_RND: state_q <= ST_ERR;
        ST_ERR: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (finish) begin
            state_q <= ST_IDLE;
            if (mot_q) begin
              res_b_q      <= res_new_q;
              last_dir_b_q <= dir_q;
            end else begin
              res_a_q      <= res_new_q;
              last_dir_a_q <= dir_q;
            end
            dir_lines_q  <= dir_new;
            active_q     <= mot_q;
            period_q     <= period_new;
            elapsed_q    <= '0;
            moving_q     <= n_pos;
            steps_left_q <= n_pos ? steps_new : '0;
            out_data_q   <= emit_lines(n_pos, mot_q, '0, period_new, dir_new, 1'b0);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/stepper_move_pulse_generator.sv =====
// top level of the two-motor step/dir pulse generator with its register bank
//
// Request channel (in_valid_i / in_stall_o / in_data_i) carries tick beats and
// move beats. Each accepted beat gives exactly one result beat on the result
// channel (out_valid_o / out_stall_i / out_data_o), in order.
// A tick beat reports the step, dir and enable line levels during that tick
// and then advances the step timer; ticks flow at one beat per cycle while no
// move is computing and the result side does not stall, through the queue,
// then the result register. A move beat computes the rounded step count over
// a multiply and three add/round steps, and the step period with a bit-serial
// divider. A move that arrives while a move runs, or with zero speed, is
// refused.
// Behind a move the command queue keeps taking beats until it is full, then
// raises in_stall_o. A stall on the result side holds the result register
// and, once the queue fills, stalls the request side.
// Reset clears the queue, the motion state and residuals, and loads the
// default register values. Registers sit on an APB port at byte offsets 0, 4,
// 8, 12; the user writes them only while the block is idle (not enforced).
module stepper_move_pulse_generator #(
  parameter int unsigned QUEUE_DEPTH = smpg_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  smpg_pkg::req_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output smpg_pkg::res_t                  out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [smpg_pkg::PADDR_W-1:0]    paddr,
  input  logic [smpg_pkg::PDATA_W-1:0]    pwdata,
  output logic [smpg_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import smpg_pkg::*;

  cfg_t       cfg_q;
  logic       cfg_we;
  logic [1:0] reg_idx;
  logic       head_valid, pop;
  cmd_t       head;

  // register bank
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spdeg_a <= SPDEG_A_RST;
      cfg_q.spdeg_b <= SPDEG_B_RST;
      cfg_q.ticks_a <= TICKS_A_RST;
      cfg_q.ticks_b <= TICKS_B_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_SPDEG_A: cfg_q.spdeg_a <= pwdata[SPDEG_W-1:0];
        REG_SPDEG_B: cfg_q.spdeg_b <= pwdata[SPDEG_W-1:0];
        REG_TICKS_A: cfg_q.ticks_a <= pwdata[TICKS_W-1:0];
        REG_TICKS_B: cfg_q.ticks_b <= pwdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_SPDEG_A: prdata = PDATA_W'(cfg_q.spdeg_a);
      REG_SPDEG_B: prdata = PDATA_W'(cfg_q.spdeg_b);
      REG_TICKS_A: prdata = PDATA_W'(cfg_q.ticks_a);
      REG_TICKS_B: prdata = PDATA_W'(cfg_q.ticks_b);
      default:     prdata = '0;
    endcase
  end

  smpg_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  smpg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== tb/sv/stepper_move_pulse_generator_tb.sv =====
// testbench for the two-motor step/dir pulse generator: directed and random beats
`timescale 1ns / 100ps

module stepper_move_pulse_generator_tb;
  import smpg_pkg::*;

  // request kinds, motors, directions
  localparam logic REQ_MOVE = 1'b0;
  localparam logic REQ_TICK = 1'b1;
  localparam logic MOTOR_A  = 1'b0;
  localparam logic MOTOR_B  = 1'b1;
  localparam logic DIR_CW   = 1'b0;
  localparam logic DIR_CCW  = 1'b1;

  // fixed-point step arithmetic at 2^-20 step
  localparam longint STEP_ONE   = 64'sd1048576;
  localparam longint STEP_HALF  = 64'sd524288;
  localparam longint STEPS_CAP  = 64'sd131071;
  localparam int unsigned RUN_TAIL = 40;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  req_t               in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  res_t               out_data_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // model of the block: configuration copy
  logic [SPDEG_W-1:0] rate_cfg  [2];
  logic [TICKS_W-1:0] ticks_cfg [2];
  // model of the block: motion state
  logic [RES_W-1:0]   carry     [2];
  logic               prev_dir  [2];
  logic [STEPS_W-1:0] steps_to_go;
  logic [TICKS_W-1:0] step_period;
  logic [TICKS_W-1:0] tick_count;
  logic               cur_motor;
  logic [1:0]         dir_state;
  logic               running;

  res_t        expected_lines [$];
  int unsigned fault_count = 0;
  int unsigned beats_sent  = 0;
  bit          gaps_on     = 1'b1;

  string line_names [8] = '{"motor_a_step", "motor_a_dir", "motor_a_enable_n",
                            "motor_b_step", "motor_b_dir", "motor_b_enable_n",
                            "busy_res", "rejected"};

  stepper_move_pulse_generator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("[stepper_move_pulse_generator] ERROR");
    $finish;
  end

  // rounded step count of a move; carry_next gets the new residual
  function automatic longint round_steps(input logic [ANG_W-1:0]   angle,
                                         input logic [SPDEG_W-1:0] rate,
                                         input logic [RES_W-1:0]   carry_in,
                                         input logic               flip,
                                         output logic [RES_W-1:0]  carry_next);
    longint r, target, n, err, e16;
    r = $signed(carry_in);
    if (flip) r = -r;
    target = longint'(angle) * longint'(rate) - r * 16;
    if (target >= 0) n = (target + STEP_HALF) / STEP_ONE;
    else n = -((-target + STEP_HALF) / STEP_ONE);
    err = n * STEP_ONE - target;
    // floor to 2^-16 step
    if (err >= 0) e16 = err / 16;
    else e16 = -((-err + 15) / 16);
    carry_next = e16[RES_W-1:0];
    return n;
  endfunction

  // ticks per step, rounded half up, at least two
  function automatic logic [TICKS_W-1:0] period_of(input logic [TICKS_W-1:0] ticks,
                                                   input logic [SPD_W-1:0]   spd);
    logic [63:0] p;
    p = (64'(ticks) + 64'(spd >> 1)) / 64'(spd);
    if (p < 64'd2) p = 64'd2;
    return p[TICKS_W-1:0];
  endfunction

  // line levels seen from the current motion state
  function automatic res_t line_levels(input logic refused);
    res_t r;
    logic hi, on_a, on_b;
    hi   = running && (tick_count < (step_period >> 1));
    on_a = running && (cur_motor == MOTOR_A);
    on_b = running && (cur_motor == MOTOR_B);
    r.motor_a_step     = on_a && hi;
    r.motor_a_dir      = dir_state[0];
    r.motor_a_enable_n = !on_a;
    r.motor_b_step     = on_b && hi;
    r.motor_b_dir      = dir_state[1];
    r.motor_b_enable_n = !on_b;
    r.busy_res         = running;
    r.rejected         = refused;
    return r;
  endfunction

  // advance the model by one accepted beat and queue its result
  function automatic void predict_beat(input req_t b);
    res_t             r;
    longint           n;
    logic [RES_W-1:0] nxt;
    logic             m;
    m = b.motor_select;
    if (b.req_type == REQ_TICK) begin
      r = line_levels(1'b0);
      if (running) begin
        tick_count = tick_count + 1;
        if (tick_count >= step_period) begin
          tick_count  = '0;
          steps_to_go = steps_to_go - 1'b1;
          if (steps_to_go == '0) running = 1'b0;
        end
      end
    end else if (running || b.speed_dps == '0) begin
      r = line_levels(1'b1);
    end else begin
      n = round_steps(b.move_degrees, rate_cfg[m], carry[m], b.direction != prev_dir[m], nxt);
      carry[m]     = nxt;
      prev_dir[m]  = b.direction;
      dir_state[m] = b.direction;
      cur_motor    = m;
      step_period  = period_of(ticks_cfg[m], b.speed_dps);
      tick_count   = '0;
      if (n <= 0) begin
        steps_to_go = '0;
        running     = 1'b0;
      end else begin
        steps_to_go = (n > STEPS_CAP) ? STEPS_W'(STEPS_CAP) : STEPS_W'(n);
        running     = 1'b1;
      end
      r = line_levels(1'b0);
    end
    expected_lines.push_back(r);
  endfunction

  // ticks a move would run for, zero if it gives no steps
  function automatic longint move_ticks(input req_t b);
    logic [RES_W-1:0] carry_dummy;
    longint           n;
    logic             m;
    m = b.motor_select;
    if (b.speed_dps == '0 || running) return 0;
    n = round_steps(b.move_degrees, rate_cfg[m], carry[m], b.direction != prev_dir[m],
                    carry_dummy);
    if (n <= 0) return 0;
    if (n > STEPS_CAP) n = STEPS_CAP;
    return n * longint'(period_of(ticks_cfg[m], b.speed_dps));
  endfunction

  function automatic req_t random_beat(input logic kind);
    req_t b;
    b.req_type     = kind;
    b.motor_select = 1'($urandom);
    b.direction    = 1'($urandom);
    b.speed_dps    = SPD_W'($urandom);
    b.move_degrees = ANG_W'($urandom);
    return b;
  endfunction

  function automatic req_t move_beat(input logic motor, input logic dir,
                                     input logic [SPD_W-1:0] spd,
                                     input logic [ANG_W-1:0] angle);
    req_t b;
    b.req_type     = REQ_MOVE;
    b.motor_select = motor;
    b.direction    = dir;
    b.speed_dps    = spd;
    b.move_degrees = angle;
    return b;
  endfunction

  // random move whose run stays within the tick budget
  function automatic req_t plan_move(input longint budget);
    req_t   b;
    longint cost;
    b = random_beat(REQ_MOVE);
    b.speed_dps = SPD_W'($urandom_range(1, 1023));
    if ($urandom_range(0, 3) != 0) b.move_degrees = ANG_W'($urandom_range(0, 255));
    cost = move_ticks(b);
    while (cost > budget && b.move_degrees != '0) begin
      b.move_degrees = b.move_degrees >> 1;
      cost = move_ticks(b);
    end
    if (cost > budget) begin
      b.speed_dps = '1;
      cost = move_ticks(b);
    end
    // too slow at any speed: send it refused instead
    if (cost > budget) b.speed_dps = '0;
    return b;
  endfunction

  // send one request beat, with an optional gap in front
  task automatic send_beat(input req_t b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    predict_beat(b);
    beats_sent++;
  endtask

  // hold off the request side until every result is back
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_lines.size() != 0);
  endtask

  // tick until the running move is done, with optional refused moves mixed in
  task automatic run_out(input bit noisy);
    req_t b;
    while (running) begin
      b = random_beat(REQ_TICK);
      if (noisy && $urandom_range(0, 15) == 0) b.req_type = REQ_MOVE;
      send_beat(b);
    end
  endtask

  // apb write then read back, only while idle
  task automatic set_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] rd, want;
    wait_results_done();
    want = (idx == REG_SPDEG_A || idx == REG_SPDEG_B) ? (value & 32'h00FF_FFFF) : value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_SPDEG_A: rate_cfg[MOTOR_A]  = value[SPDEG_W-1:0];
      REG_SPDEG_B: rate_cfg[MOTOR_B]  = value[SPDEG_W-1:0];
      REG_TICKS_A: ticks_cfg[MOTOR_A] = value;
      REG_TICKS_B: ticks_cfg[MOTOR_B] = value;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== want) begin
      fault_count++;
      $display("%0t: register %0d read expected %h got %h", $time, idx, want, rd);
    end
  endtask

  // ticks with no move show the idle lines
  task automatic test_idle_ticks();
    repeat (4) send_beat(random_beat(REQ_TICK));
  endtask

  // half-step rounding, negative counts and residual flip on direction change
  task automatic test_rounding_carry();
    set_reg(REG_SPDEG_A, 32'd524288);
    set_reg(REG_TICKS_A, 32'd4);
    send_beat(move_beat(MOTOR_A, DIR_CW, 10'd2, 16'd1));
    run_out(1'b0);
    send_beat(move_beat(MOTOR_A, DIR_CW, 10'd2, 16'd0));
    send_beat(move_beat(MOTOR_A, DIR_CCW, 10'd2, 16'd0));
    send_beat(move_beat(MOTOR_A, DIR_CCW, 10'd3, 16'd3));
    run_out(1'b0);
  endtask

  // smallest and largest register values with moves that give no steps
  task automatic test_extreme_registers();
    set_reg(REG_SPDEG_A, 32'd1);
    set_reg(REG_TICKS_A, 32'hFFFF_FFFF);
    set_reg(REG_SPDEG_B, 32'h00FF_FFFF);
    set_reg(REG_TICKS_B, 32'hFFFF_FFFF);
    send_beat(move_beat(MOTOR_A, DIR_CW, 10'd1, 16'hFFFF));
    send_beat(move_beat(MOTOR_A, DIR_CCW, 10'd1023, 16'd0));
    send_beat(move_beat(MOTOR_B, DIR_CW, 10'd1, 16'd0));
    send_beat(move_beat(MOTOR_B, DIR_CCW, 10'd1023, 16'd0));
    repeat (2) send_beat(random_beat(REQ_TICK));
  endtask

  // ordinary moves on both motors, both directions
  task automatic test_basic_moves();
    set_reg(REG_SPDEG_A, 32'(SPDEG_A_RST));
    set_reg(REG_SPDEG_B, 32'(SPDEG_B_RST));
    set_reg(REG_TICKS_A, 32'd40);
    set_reg(REG_TICKS_B, 32'd300);
    send_beat(move_beat(MOTOR_A, DIR_CW, 10'd10, 16'd8));
    run_out(1'b0);
    send_beat(move_beat(MOTOR_B, DIR_CCW, 10'd100, 16'd16));
    run_out(1'b0);
    send_beat(move_beat(MOTOR_B, DIR_CW, 10'd1023, 16'd16));
    run_out(1'b0);
    send_beat(move_beat(MOTOR_A, DIR_CCW, 10'd5, 16'd3));
    run_out(1'b0);
  endtask

  // moves while busy and moves with zero speed are refused
  task automatic test_refusals();
    send_beat(move_beat(MOTOR_A, DIR_CW, 10'd20, 16'd4));
    send_beat(move_beat(MOTOR_B, DIR_CCW, 10'd500, 16'd40));
    send_beat(random_beat(REQ_TICK));
    send_beat(move_beat(MOTOR_A, DIR_CCW, 10'd0, 16'd7));
    run_out(1'b1);
    send_beat(move_beat(MOTOR_B, DIR_CW, 10'd0, 16'd100));
    send_beat(random_beat(REQ_TICK));
  endtask

  function automatic logic [PDATA_W-1:0] pick_rate();
    case ($urandom_range(0, 5))
      0:       return 32'd1;
      1:       return 32'h00FF_FFFF;
      2, 3:    return $urandom_range(1, 32'h0008_0000);
      default: return $urandom_range(1, 32'h00FF_FFFF);
    endcase
  endfunction

  function automatic logic [PDATA_W-1:0] pick_ticks();
    case ($urandom_range(0, 6))
      0:       return 32'd1;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(1, 200);
      default: return $urandom_range(1, 100000);
    endcase
  endfunction

  // random phases: well-formed moves run out, with noise and pauses
  task automatic test_random();
    int unsigned phase_end;
    req_t        b;
    for (int phase = 0; phase < 6; phase++) begin
      set_reg(REG_SPDEG_A, pick_rate());
      set_reg(REG_SPDEG_B, pick_rate());
      set_reg(REG_TICKS_A, pick_ticks());
      set_reg(REG_TICKS_B, pick_ticks());
      gaps_on   = (phase != 2);
      phase_end = beats_sent + 300;
      while (beats_sent < phase_end) begin
        case ($urandom_range(0, 19))
          0: send_beat(random_beat(REQ_TICK));
          1: begin
            b = random_beat(REQ_MOVE);
            b.speed_dps = '0;
            send_beat(b);
          end
          2: wait_results_done();
          default: begin
            send_beat(plan_move(($urandom_range(0, 3) == 0) ? 400 : 60));
            run_out(1'b1);
          end
        endcase
      end
    end
  endtask

  // a move past the step cap starts running; moves behind it are refused
  task automatic test_saturation();
    gaps_on = 1'b0;
    set_reg(REG_SPDEG_A, 32'h00FF_FFFF);
    set_reg(REG_TICKS_A, 32'd1);
    send_beat(move_beat(MOTOR_A, DIR_CW, 10'd1023, 16'hFFFF));
    repeat (24) send_beat(random_beat(REQ_TICK));
    send_beat(move_beat(MOTOR_A, DIR_CW, 10'd1023, 16'd1));
    repeat (8) send_beat(random_beat(REQ_TICK));
  endtask

  // receiver stalls in bursts
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // compare each result beat with the oldest expected lines
  always @(posedge clk_i) begin
    res_t                    want;
    logic [$bits(res_t)-1:0] w, g;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_lines.size() == 0) begin
        fault_count++;
        $display("%0t: result beat with none expected, got %b", $time, out_data_o);
      end else begin
        want = expected_lines.pop_front();
        w    = want;
        g    = out_data_o;
        for (int i = $bits(res_t) - 1; i >= 0; i--) begin
          if (w[i] !== g[i]) begin
            fault_count++;
            $display("%0t: %s expected %b got %b", $time,
                     line_names[$bits(res_t) - 1 - i], w[i], g[i]);
          end
        end
      end
    end
  end

  // main sequence
  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    rate_cfg[MOTOR_A]  = SPDEG_A_RST;
    rate_cfg[MOTOR_B]  = SPDEG_B_RST;
    ticks_cfg[MOTOR_A] = TICKS_A_RST;
    ticks_cfg[MOTOR_B] = TICKS_B_RST;
    carry[MOTOR_A]     = '0;
    carry[MOTOR_B]     = '0;
    prev_dir[MOTOR_A]  = DIR_CW;
    prev_dir[MOTOR_B]  = DIR_CW;
    steps_to_go        = '0;
    step_period        = '0;
    tick_count         = '0;
    cur_motor          = MOTOR_A;
    dir_state          = '0;
    running            = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_ticks();
    test_rounding_carry();
    test_extreme_registers();
    test_basic_moves();
    test_refusals();
    test_random();
    test_saturation();

    wait_results_done();
    repeat (RUN_TAIL) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("[stepper_move_pulse_generator] OK");
    end else begin
      $display("[stepper_move_pulse_generator] ERROR");
    end
    $finish;
  end

endmodule
